### rtl/sltab_pkg.sv
package sltab_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FOUND    = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  // Table read address select
  localparam logic [1:0] RD_MID = 2'd0;
  localparam logic [1:0] RD_LO  = 2'd1;
  localparam logic [1:0] RD_SRC = 2'd2;

  // Table write select
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_UP    = 2'd1;
  localparam logic [1:0] WR_DN    = 2'd2;
  localparam logic [1:0] WR_ENTRY = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] key;
    logic [15:0] payload;
  } sltab_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slot;
    logic [8:0] entries;
  } sltab_out_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] handle;
  } sltab_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       fill_clr;
    logic       lo_step;
    logic       hi_step;
    logic       src_up_init;
    logic       src_dn_init;
    logic       src_dec;
    logic       src_inc;
    logic       fill_inc;
    logic       fill_dec;
    logic [1:0] rd_sel;
    logic [1:0] wr_sel;
    logic       out_load;
    logic [2:0] out_status;
    logic       out_slot_en;
  } sltab_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       lo_lt_hi;
    logic       lo_lt_fill;
    logic       key_lt;
    logic       key_eq;
    logic       full;
    logic       up_last;
    logic       dn_last;
    logic       has_tail;
    logic       out_free;
    logic [1:0] mode;
  } sltab_stat_t;

endpackage

### rtl/sorted_line_number_table.sv
// Sorted line number table: up to TABLE_DEPTH entries kept in ascending key
// order, each with a 16-bit payload handle.
// Input channel (in_valid/in_ready/in_data) takes one operation per beat:
// insert or replace, delete, find or clear. Output channel
// (out_valid/out_ready/out_data) returns one result beat per operation with
// status, slot index and entry count after the operation.
// One operation is in flight at a time; in_ready is high only while idle.
// Steps of an operation: an accept state, a binary search over the table RAM
// with a read and a compare state per probe, a key check if the search stops
// on a stored entry, then a read and a write state per entry moved through the
// single RAM port pair, a write of the new entry for insert, and a load of the
// result register. Clear goes from accept straight to the result; a find or
// delete on an empty table reads no entry from the RAM.
// The result register holds its beat while out_ready is low; the next
// operation can be accepted as soon as the previous result is registered.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; table contents are not cleared and need no sweep.
module sorted_line_number_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sltab_pkg::sltab_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sltab_pkg::sltab_out_t out_data
);

  import sltab_pkg::*;

  sltab_cmd_t  cmd;
  sltab_stat_t stat;

  sltab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sltab_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/sltab_ram.sv
module sltab_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/sltab_ctrl.sv
module sltab_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_mode,
  output logic                  in_ready,
  input  sltab_pkg::sltab_stat_t stat,
  output sltab_pkg::sltab_cmd_t  cmd
);

  import sltab_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;
  localparam logic [3:0] S_SCMP   = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_UPRD   = 4'd4;
  localparam logic [3:0] S_UPWR   = 4'd5;
  localparam logic [3:0] S_INSWR  = 4'd6;
  localparam logic [3:0] S_DNRD   = 4'd7;
  localparam logic [3:0] S_DNWR   = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [2:0] st_r, st_nxt;
  logic       slot_en_r, slot_en_nxt;

  // Next state, status code and datapath commands
  always_comb begin
    logic decide;
    logic found;
    state_nxt   = state_r;
    st_nxt      = st_r;
    slot_en_nxt = slot_en_r;
    cmd         = '0;
    cmd.rd_sel  = RD_MID;
    cmd.wr_sel  = WR_NONE;
    in_ready    = 1'b0;
    decide      = 1'b0;
    found       = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_mode == MODE_CLEAR) begin
            cmd.fill_clr = 1'b1;
            st_nxt       = ST_CLEARED;
            slot_en_nxt  = 1'b0;
            state_nxt    = S_RESULT;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      // Binary search for the first key not below the requested one
      S_SRD: begin
        if (stat.lo_lt_hi) begin
          cmd.rd_sel = RD_MID;
          state_nxt  = S_SCMP;
        end else if (stat.lo_lt_fill) begin
          cmd.rd_sel = RD_LO;
          state_nxt  = S_CHK;
        end else begin
          decide = 1'b1;
        end
      end
      S_SCMP: begin
        if (stat.key_lt) begin
          cmd.lo_step = 1'b1;
        end else begin
          cmd.hi_step = 1'b1;
        end
        state_nxt = S_SRD;
      end
      S_CHK: begin
        decide = 1'b1;
        found  = stat.key_eq;
      end
      // Shift the tail up one entry, top first
      S_UPRD: begin
        cmd.rd_sel = RD_SRC;
        state_nxt  = S_UPWR;
      end
      S_UPWR: begin
        cmd.wr_sel = WR_UP;
        if (stat.up_last) begin
          state_nxt = S_INSWR;
        end else begin
          cmd.src_dec = 1'b1;
          state_nxt   = S_UPRD;
        end
      end
      S_INSWR: begin
        cmd.wr_sel   = WR_ENTRY;
        cmd.fill_inc = 1'b1;
        st_nxt       = ST_INSERTED;
        slot_en_nxt  = 1'b1;
        state_nxt    = S_RESULT;
      end
      // Shift the tail down one entry, bottom first
      S_DNRD: begin
        cmd.rd_sel = RD_SRC;
        state_nxt  = S_DNWR;
      end
      S_DNWR: begin
        cmd.wr_sel = WR_DN;
        if (stat.dn_last) begin
          cmd.fill_dec = 1'b1;
          st_nxt       = ST_DELETED;
          slot_en_nxt  = 1'b1;
          state_nxt    = S_RESULT;
        end else begin
          cmd.src_inc = 1'b1;
          state_nxt   = S_DNRD;
        end
      end
      // Hand the result to the output register once it is free
      S_RESULT: begin
        cmd.out_status  = st_r;
        cmd.out_slot_en = slot_en_r;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Act on the search outcome
    if (decide) begin
      state_nxt = S_RESULT;
      case (stat.mode)
        MODE_INSERT: begin
          if (found) begin
            cmd.wr_sel  = WR_ENTRY;
            st_nxt      = ST_REPLACED;
            slot_en_nxt = 1'b1;
          end else if (stat.full) begin
            st_nxt      = ST_FULL;
            slot_en_nxt = 1'b0;
          end else if (stat.lo_lt_fill) begin
            cmd.src_up_init = 1'b1;
            state_nxt       = S_UPRD;
          end else begin
            state_nxt = S_INSWR;
          end
        end
        MODE_DELETE: begin
          if (found && stat.has_tail) begin
            cmd.src_dn_init = 1'b1;
            state_nxt       = S_DNRD;
          end else if (found) begin
            cmd.fill_dec = 1'b1;
            st_nxt       = ST_DELETED;
            slot_en_nxt  = 1'b1;
          end else begin
            st_nxt      = ST_NOTFOUND;
            slot_en_nxt = 1'b0;
          end
        end
        MODE_FIND: begin
          st_nxt      = found ? ST_FOUND : ST_NOTFOUND;
          slot_en_nxt = found;
        end
        default: begin
          st_nxt      = ST_NOTFOUND;
          slot_en_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r      <= st_nxt;
    slot_en_r <= slot_en_nxt;
  end

endmodule

### rtl/sltab_dp.sv
module sltab_dp #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sltab_pkg::sltab_in_t   in_data,
  input  sltab_pkg::sltab_cmd_t  cmd,
  output sltab_pkg::sltab_stat_t stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sltab_pkg::sltab_out_t  out_data
);

  import sltab_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $bits(sltab_entry_t);

  logic [1:0]    mode_r;
  logic [15:0]   key_r;
  logic [15:0]   pay_r;
  logic [CW-1:0] lo_r, hi_r, src_r, fill_r;
  logic          out_valid_r;
  sltab_out_t    out_r;

  logic [CW:0]   sum;
  logic [CW-1:0] mid, mid_p1, src_p1, src_m1, lo_p1;
  sltab_entry_t  rd_ent, wr_ent;
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  assign sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid    = sum[CW:1];
  assign mid_p1 = mid + CW'(1);
  assign src_p1 = src_r + CW'(1);
  assign src_m1 = src_r - CW'(1);
  assign lo_p1  = lo_r + CW'(1);
  assign rd_ent = sltab_entry_t'(rdata);

  // Select read address
  always_comb begin
    case (cmd.rd_sel)
      RD_LO:   raddr = lo_r[AW-1:0];
      RD_SRC:  raddr = src_r[AW-1:0];
      default: raddr = mid[AW-1:0];
    endcase
  end

  // Select write address and data
  always_comb begin
    we     = 1'b1;
    waddr  = lo_r[AW-1:0];
    wr_ent = rd_ent;
    case (cmd.wr_sel)
      WR_UP:   waddr = src_p1[AW-1:0];
      WR_DN:   waddr = src_m1[AW-1:0];
      WR_ENTRY: begin
        wr_ent.key    = key_r;
        wr_ent.handle = pay_r;
      end
      default: we = 1'b0;
    endcase
  end

  sltab_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_ent),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Latch the request and step the search bounds and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      key_r  <= in_data.key;
      pay_r  <= in_data.payload;
      lo_r   <= '0;
      hi_r   <= fill_r;
    end
    if (cmd.lo_step) begin
      lo_r <= mid_p1;
    end
    if (cmd.hi_step) begin
      hi_r <= mid;
    end
    if (cmd.src_up_init) begin
      src_r <= fill_r - CW'(1);
    end else if (cmd.src_dn_init) begin
      src_r <= lo_p1;
    end else if (cmd.src_dec) begin
      src_r <= src_m1;
    end else if (cmd.src_inc) begin
      src_r <= src_p1;
    end
  end

  // Track the entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.fill_clr) begin
      fill_r <= '0;
    end else if (cmd.fill_inc) begin
      fill_r <= fill_r + CW'(1);
    end else if (cmd.fill_dec) begin
      fill_r <= fill_r - CW'(1);
    end
  end

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status  <= cmd.out_status;
      out_r.slot    <= cmd.out_slot_en ? 8'(lo_r) : 8'd0;
      out_r.entries <= 9'(fill_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.lo_lt_hi   = lo_r < hi_r;
  assign stat.lo_lt_fill = lo_r < fill_r;
  assign stat.key_lt     = rd_ent.key < key_r;
  assign stat.key_eq     = rd_ent.key == key_r;
  assign stat.full       = fill_r == CW'(TABLE_DEPTH);
  assign stat.up_last    = src_r == lo_r;
  assign stat.dn_last    = src_p1 == fill_r;
  assign stat.has_tail   = lo_p1 < fill_r;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.mode       = mode_r;

endmodule

### test/sorted_line_number_table_tb.sv
module sorted_line_number_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sltab_pkg::*;

  localparam int unsigned DEPTH        = 256;
  localparam int          RANDOM_ITEMS = 950;
  localparam longint      LIMIT_CYCLES = 4_000_000;

  // Running model of the table plus the queue of results still owed by the block
  class line_table_ledger;
    logic [15:0] keys [DEPTH];
    logic [15:0] handles [DEPTH];
    int unsigned fill;
    sltab_out_t  awaited [$];
    int          errors;
    int          edits;
    int          peak_fill;
    int          status_seen [7];

    function new();
      fill = 0;
      errors = 0;
      edits = 0;
      peak_fill = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_edit(sltab_in_t beat);
      sltab_out_t  res;
      int unsigned pos;
      int unsigned i;
      pos = fill;
      for (i = 0; i < fill; i++) begin
        if (keys[i] == beat.key) begin
          pos = i;
          break;
        end
      end
      res = '0;
      case (beat.mode)
        MODE_INSERT: begin
          if (pos < fill) begin
            handles[pos] = beat.payload;
            res.status = ST_REPLACED;
            res.slot = pos[7:0];
          end else if (fill >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            // shift larger keys up one place
            i = fill;
            while (i > 0 && keys[i-1] > beat.key) begin
              keys[i] = keys[i-1];
              handles[i] = handles[i-1];
              i--;
            end
            keys[i] = beat.key;
            handles[i] = beat.payload;
            fill++;
            res.status = ST_INSERTED;
            res.slot = i[7:0];
          end
        end
        MODE_DELETE: begin
          if (pos < fill) begin
            // close the gap
            for (i = pos; i + 1 < fill; i++) begin
              keys[i] = keys[i+1];
              handles[i] = handles[i+1];
            end
            fill--;
            res.status = ST_DELETED;
            res.slot = pos[7:0];
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
        MODE_FIND: begin
          if (pos < fill) begin
            res.status = ST_FOUND;
            res.slot = pos[7:0];
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
        default: begin
          fill = 0;
          res.status = ST_CLEARED;
        end
      endcase
      res.entries = fill[8:0];
      if (fill > peak_fill) peak_fill = fill;
      status_seen[res.status]++;
      edits++;
      awaited.push_back(res);
    endfunction

    // Compare one result beat against the oldest owed result
    function void check_reply(sltab_out_t got);
      sltab_out_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result beat %p arrived with no operation outstanding", $time, got);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.slot !== want.slot)
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
        if (got.entries !== want.entries)
          $display("%0t: entries expected %0d actual %0d", $time, want.entries,
                   got.entries);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  sltab_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  sltab_out_t out_data;

  line_table_ledger ledger;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_span = 0;
  int     hold_seq = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  longint cycles = 0;

  sorted_line_number_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: no progress after %0d cycles, %0d results outstanding", $time, cycles,
               ledger.pending());
      $display("sorted_line_number_table regression: fail");
      $finish;
    end
  end

  // Result side: check accepted beats, stall at random, serve hold-off requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) ledger.check_reply(out_data);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_span;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic set_idling(int style);
    case (style)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 47; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 47; end
      default: begin idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  // Present one operation, hold it until accepted, then maybe go idle a while
  task automatic offer(sltab_in_t beat);
    in_data <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_edit(beat);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Favor keys that hit the table so replace, delete and find take effect
  function automatic logic [15:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45 && ledger.fill > 0)
      return ledger.keys[$urandom_range(ledger.fill - 1)];
    if (roll < 55 && ledger.fill > 0)
      return ledger.keys[$urandom_range(ledger.fill - 1)] +
             ($urandom_range(1) ? 16'h0001 : 16'hFFFF);
    if (roll < 70) return 16'($urandom_range(31));
    if (roll < 76) begin
      case ($urandom_range(3))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'h7FFF;
        default: return 16'h8000;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic sltab_in_t random_edit(int ins_pct, int del_pct, int find_pct);
    sltab_in_t beat;
    int roll;
    beat.key = pick_key();
    beat.payload = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                            : 16'($urandom);
    roll = $urandom_range(99);
    if (roll < ins_pct) beat.mode = MODE_INSERT;
    else if (roll < ins_pct + del_pct) beat.mode = MODE_DELETE;
    else if (roll < ins_pct + del_pct + find_pct) beat.mode = MODE_FIND;
    else beat.mode = MODE_CLEAR;
    // occasional unstructured beat
    if ($urandom_range(19) == 0) beat = sltab_in_t'({$urandom, $urandom});
    return beat;
  endfunction

  // Fill the table to capacity, then probe it at the top
  task automatic fill_to_top(bit ascending);
    logic [15:0] probe;
    offer('{MODE_CLEAR, 16'($urandom), 16'($urandom)});
    while (ledger.fill < DEPTH) begin
      if (ascending) probe = 16'(ledger.fill * 250 + $urandom_range(249));
      else probe = 16'($urandom);
      offer('{MODE_INSERT, probe, 16'($urandom)});
    end
    offer('{MODE_INSERT, 16'($urandom), 16'($urandom)});
    offer('{MODE_INSERT, 16'hFFFF, 16'hFFFF});
    offer('{MODE_INSERT, 16'h0000, 16'h0000});
    offer('{MODE_INSERT, ledger.keys[0], 16'h5A5A});
    offer('{MODE_FIND, ledger.keys[DEPTH-1], 16'($urandom)});
    probe = ledger.keys[DEPTH-1];
    offer('{MODE_DELETE, probe, 16'($urandom)});
    offer('{MODE_INSERT, probe, 16'hA5A5});
    probe = ledger.keys[0];
    offer('{MODE_DELETE, probe, 16'($urandom)});
    offer('{MODE_FIND, probe, 16'($urandom)});
    offer('{MODE_INSERT, probe, 16'h0001});
    offer('{MODE_INSERT, 16'($urandom), 16'($urandom)});
  endtask

  initial begin
    int style;
    int kind;
    int sent;
    sltab_in_t beat;

    ledger = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, shifts both ways, replace, stale entries after clear
    set_idling(3);
    offer('{MODE_FIND, 16'h0000, 16'h0000});
    offer('{MODE_DELETE, 16'hFFFF, 16'hFFFF});
    offer('{MODE_INSERT, 16'h8000, 16'hFFFF});
    offer('{MODE_INSERT, 16'h0000, 16'h0000});
    offer('{MODE_INSERT, 16'hFFFF, 16'hAAAA});
    offer('{MODE_INSERT, 16'h8000, 16'h5555});
    offer('{MODE_FIND, 16'hFFFF, 16'h1234});
    offer('{MODE_FIND, 16'h1234, 16'h0000});
    offer('{MODE_INSERT, 16'h7FFF, 16'h0001});
    offer('{MODE_DELETE, 16'h0000, 16'hFFFF});
    offer('{MODE_DELETE, 16'h0000, 16'h0000});
    offer('{MODE_DELETE, 16'hFFFF, 16'h0000});
    offer('{MODE_CLEAR, 16'hFFFF, 16'hFFFF});
    offer('{MODE_FIND, 16'h8000, 16'h0000});
    offer('{MODE_DELETE, 16'h7FFF, 16'h0000});
    offer('{MODE_CLEAR, 16'h0000, 16'h0000});
    offer('{MODE_INSERT, 16'h8000, 16'h0000});
    offer('{MODE_DELETE, 16'h8000, 16'h0000});
    offer('{MODE_INSERT, 16'h5555, 16'hFFFF});
    offer('{MODE_FIND, 16'h5555, 16'h0000});

    // Capacity: ascending fill without shifts, then random order with shifts
    set_idling(0);
    fill_to_top(1'b1);
    set_idling(3);
    fill_to_top(1'b0);
    offer('{MODE_CLEAR, 16'($urandom), 16'($urandom)});

    // Back-pressure: hold off the result side while operations keep coming
    set_idling(0);
    hold_span = 400;
    hold_seq++;

    // Random episodes: grow, churn or drain, rotating the idling style
    sent = 0;
    style = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent > 0) set_idling(style);
      style = (style + 1) % 4;
      kind = $urandom_range(2);
      repeat ($urandom_range(40, 120)) begin
        if (ledger.fill > 200) kind = 2;
        case (kind)
          0: beat = random_edit(80, 8, 11);
          1: beat = random_edit(40, 30, 29);
          default: beat = random_edit(15, 60, 22);
        endcase
        offer(beat);
        sent++;
      end
    end

    // Drain
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("ran %0d table operations (%0d random), table filled to capacity twice, peak %0d",
             ledger.edits, sent, ledger.peak_fill);
    $display("outcomes: ins %0d repl %0d full %0d del %0d miss %0d hit %0d clr %0d",
             ledger.status_seen[ST_INSERTED], ledger.status_seen[ST_REPLACED],
             ledger.status_seen[ST_FULL], ledger.status_seen[ST_DELETED],
             ledger.status_seen[ST_NOTFOUND], ledger.status_seen[ST_FOUND],
             ledger.status_seen[ST_CLEARED]);
    if (ledger.errors == 0) begin
      $display("sorted_line_number_table regression: pass");
    end else begin
      $display("sorted_line_number_table regression: fail");
    end
    $finish;
  end

endmodule
